### src/belt_block_cipher_unit_assert.svh
// ------------------------------------------------------------------------
// belt block cipher assertion macros
// shared concurrent assertion forms, sampled on aclk, off during reset
// ------------------------------------------------------------------------
`ifndef BELT_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define BELT_BLOCK_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication
`define BELT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BELT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/belt_pkg.sv
// ------------------------------------------------------------------------
// belt package
// types, register indexes, s-box and the g function of the belt cipher
// ------------------------------------------------------------------------
package belt_pkg;

    localparam int ROUNDS = 8;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_PART_0 = 3'd0;
    localparam logic [2:0] REG_KEY_PART_1 = 3'd1;
    localparam logic [2:0] REG_KEY_PART_2 = 3'd2;
    localparam logic [2:0] REG_KEY_PART_3 = 3'd3;
    localparam logic [2:0] REG_KEY_MODE   = 3'd4;

    // key length modes
    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef logic [7:0][31:0] key_t;

    typedef struct packed {
        logic        valid;
        logic        action;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } stage_t;

    localparam logic [7:0] SBOX_H [256] = '{
        8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
        8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
        8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
        8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
        8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
        8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
        8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
        8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
        8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
        8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
        8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
        8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
        8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
        8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
        8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
        8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };

    // byte substitution then rotate left by a constant amount
    function automatic logic [31:0] g_fn(input logic [31:0] u, input int unsigned rot);
        logic [31:0] h;
        h = {SBOX_H[u[31:24]], SBOX_H[u[23:16]], SBOX_H[u[15:8]], SBOX_H[u[7:0]]};
        return (h << rot) | (h >> (32 - rot));
    endfunction

    // key word for a step of a round: decrypt walks the schedule backwards
    function automatic logic [31:0] key_sel(input key_t w, input logic [2:0] step,
                                            input logic [2:0] rnd, input logic act);
        logic [2:0] idx;
        idx = step - rnd;
        if (act == ACT_DECRYPT) begin
            idx = ~idx;
        end
        return w[idx];
    endfunction

endpackage

### src/belt_key_sched.sv
// ------------------------------------------------------------------------
// belt key schedule
// key registers, key length mode and the eight-word expanded key
// ------------------------------------------------------------------------
module belt_key_sched (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_addr,
    input  logic [63:0]       cfg_wdata,
    output belt_pkg::key_t    key_words
);
    import belt_pkg::*;

    logic [63:0] part0_reg, part1_reg, part2_reg, part3_reg;
    logic [1:0]  mode_reg;
    key_t        raw_words;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part0_reg <= '0;
            part1_reg <= '0;
            part2_reg <= '0;
            part3_reg <= '0;
            mode_reg  <= MODE_256;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_KEY_PART_0: part0_reg <= cfg_wdata;
                REG_KEY_PART_1: part1_reg <= cfg_wdata;
                REG_KEY_PART_2: part2_reg <= cfg_wdata;
                REG_KEY_PART_3: part3_reg <= cfg_wdata;
                REG_KEY_MODE:   mode_reg  <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    assign raw_words = {part3_reg, part2_reg, part1_reg, part0_reg};

    always_comb begin
        key_words = raw_words;
        unique case (mode_reg)
            MODE_128: begin
                key_words[7:4] = raw_words[3:0];
            end
            MODE_192: begin
                key_words[6] = raw_words[0] ^ raw_words[1] ^ raw_words[2];
                key_words[7] = raw_words[3] ^ raw_words[4] ^ raw_words[5];
            end
            default: begin
            end
        endcase
    end

endmodule

### src/belt_round.sv
// ------------------------------------------------------------------------
// belt round
// one cipher round cut into four register stages, encrypt or decrypt
// ------------------------------------------------------------------------
module belt_round (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic [2:0]        round_idx,
    input  belt_pkg::key_t    key_words,
    input  belt_pkg::stage_t  stage_in,
    output belt_pkg::stage_t  stage_out
);
    import belt_pkg::*;

    stage_t st1_reg, st1_next;
    stage_t st2_reg, st2_next;
    stage_t st3_reg, st3_next;
    stage_t st4_reg, st4_next;
    logic [3:0]  iter1;
    logic [31:0] e_word;
    logic [31:0] c_fin;

    always_comb begin
        st1_next   = stage_in;
        st1_next.b = stage_in.b ^ g_fn(stage_in.a
                     + key_sel(key_words, 3'd0, round_idx, stage_in.action), 5);
        st1_next.c = stage_in.c ^ g_fn(stage_in.d
                     + key_sel(key_words, 3'd1, round_idx, stage_in.action), 21);
    end

    // round number as the standard counts it, mixed into e
    assign iter1 = (st1_reg.action == ACT_DECRYPT) ? (4'd8 - {1'b0, round_idx})
                                                   : ({1'b0, round_idx} + 4'd1);

    always_comb begin
        e_word     = g_fn(st1_reg.b + st1_reg.c
                     + key_sel(key_words, 3'd3, round_idx, st1_reg.action), 21)
                     ^ {28'd0, iter1};
        st2_next   = st1_reg;
        st2_next.a = st1_reg.a - g_fn(st1_reg.b
                     + key_sel(key_words, 3'd2, round_idx, st1_reg.action), 13);
        st2_next.b = st1_reg.b + e_word;
        st2_next.c = st1_reg.c - e_word;
    end

    always_comb begin
        st3_next   = st2_reg;
        st3_next.d = st2_reg.d + g_fn(st2_reg.c
                     + key_sel(key_words, 3'd4, round_idx, st2_reg.action), 13);
        st3_next.b = st2_reg.b ^ g_fn(st2_reg.a
                     + key_sel(key_words, 3'd5, round_idx, st2_reg.action), 21);
    end

    // last step, then the word shuffle that ends the round
    always_comb begin
        c_fin    = st3_reg.c ^ g_fn(st3_reg.d
                   + key_sel(key_words, 3'd6, round_idx, st3_reg.action), 5);
        st4_next = st3_reg;
        if (st3_reg.action == ACT_DECRYPT) begin
            st4_next.a = c_fin;
            st4_next.b = st3_reg.a;
            st4_next.c = st3_reg.d;
            st4_next.d = st3_reg.b;
        end else begin
            st4_next.a = st3_reg.b;
            st4_next.b = st3_reg.d;
            st4_next.c = st3_reg.a;
            st4_next.d = c_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.valid <= 1'b0;
            st2_reg.valid <= 1'b0;
            st3_reg.valid <= 1'b0;
            st4_reg.valid <= 1'b0;
        end else if (ce) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
        end
    end

    assign stage_out = st4_reg;

endmodule

### src/belt_out_skid.sv
// ------------------------------------------------------------------------
// belt output skid
// output register plus one skid entry, decouples the pipeline from m_tready
// ------------------------------------------------------------------------
module belt_out_skid (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic [127:0]  in_data,
    output logic          in_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata
);
    import belt_pkg::*;
    `include "belt_block_cipher_unit_assert.svh"

    logic         out_valid_reg, out_valid_next;
    logic [127:0] out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [127:0] skid_data_reg, skid_data_next;
    logic         out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (out_free) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `BELT_ASSERT_NOW(skid_implies_out, skid_valid_reg, out_valid_reg,
        "skid entry held while output register empty")
    `BELT_ASSERT_NEXT(skid_drains, skid_valid_reg && m_tready, !skid_valid_reg,
        "skid entry not moved to output after a take")
    `BELT_ASSERT_NEXT(skid_fills_only_on_stall,
        !skid_valid_reg && in_valid && out_free, !skid_valid_reg,
        "item parked in skid although output was free")

endmodule

### src/belt_block_cipher_unit.sv
// ------------------------------------------------------------------------
// belt block cipher unit
// pipelined belt block encrypt/decrypt with 128/192/256-bit key expansion
// ------------------------------------------------------------------------
// One 128-bit block enters and one result leaves per clock when not stalled;
// the action bit on s_tuser picks encrypt or decrypt per item, so both may
// mix freely. An item passes one input register, eight rounds of four stages
// each (one or two g steps per stage, adder plus s-box plus rotate), and the
// output register. A stalled output holds one more item in a skid entry, and
// the pipeline halts only once that entry is full. Key registers must be
// written through the cfg port only while the unit is idle, which the block
// does not enforce; the expanded key follows the key length mode at once.
module belt_block_cipher_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_addr,
    input  logic [63:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // block_low [63:0], block_high [127:64]
    input  logic [0:0]    s_tuser,   // action [0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata    // result_low [63:0], result_high [127:64]
);
    import belt_pkg::*;

    key_t         key_words;
    stage_t       in_reg, in_next;
    stage_t       round_link [ROUNDS+1];
    stage_t       last;
    logic         ce;
    logic [127:0] result;

    belt_key_sched u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .key_words (key_words)
    );

    assign s_tready = ce;

    always_comb begin
        in_next.valid  = s_tvalid;
        in_next.action = s_tuser[0];
        in_next.a      = s_tdata[31:0];
        in_next.b      = s_tdata[63:32];
        in_next.c      = s_tdata[95:64];
        in_next.d      = s_tdata[127:96];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (ce) begin
            in_reg <= in_next;
        end
    end

    assign round_link[0] = in_reg;

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        belt_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .round_idx (3'(r)),
            .key_words (key_words),
            .stage_in  (round_link[r]),
            .stage_out (round_link[r+1])
        );
    end

    assign last = round_link[ROUNDS];

    // final word order differs between the two directions
    always_comb begin
        if (last.action == ACT_DECRYPT) begin
            result = {last.b, last.d, last.a, last.c};
        end else begin
            result = {last.c, last.a, last.d, last.b};
        end
    end

    belt_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (last.valid),
        .in_data  (result),
        .in_ready (ce),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### dv/tb_top.sv
// ------------------------------------------------------------------------
// belt block cipher unit testbench
// drives blocks and key writes over the stream and cfg ports, predicts each
// result with an independent cipher model or a known vector, checks in order
// ------------------------------------------------------------------------
module tb_top;
    import belt_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 500000;

    // cfg indexes past the key mode register decode to nothing
    localparam logic [2:0] REG_UNMAPPED_FIRST = 3'd5;
    localparam logic [2:0] REG_UNMAPPED_LAST  = 3'd7;

    // published test vector, byte 0 in the low bits of each half
    localparam logic [63:0] STD_KEY_0 = 64'hA60F0C8F_2CE7DEE9;
    localparam logic [63:0] STD_KEY_1 = 64'h4796736F_F449DB2D;
    localparam logic [63:0] STD_KEY_2 = 64'h377A24ED_16530706;
    localparam logic [63:0] STD_KEY_3 = 64'hF68BA903_83A3CB39;
    localparam logic [63:0] STD_PT_LO = 64'h3BF5080A_C8BA94B1;
    localparam logic [63:0] STD_PT_HI = 64'hE45D4A58_8E006D36;
    localparam logic [63:0] STD_CT_LO = 64'hE3C95735_C9A1CC69;
    localparam logic [63:0] STD_CT_HI = 64'h6EFA88FA_E0C36BD6;
    localparam logic [63:0] ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] H_BOX [256] = '{
        8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
        8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
        8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
        8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
        8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
        8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
        8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
        8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
        8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
        8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
        8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
        8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
        8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
        8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
        8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
        8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } blk_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_BLOCK, ROW_KNOWN} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] val;
        logic        act;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] exp_lo;
        logic [63:0] exp_hi;
    } row_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_addr;
    logic [63:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;
    logic [0:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [127:0]  m_tdata;

    logic [63:0]   key_regs [4];
    logic [1:0]    key_mode;
    blk_t          expected_blocks [$];
    row_t          directed_rows [$];
    int            error_count;
    int            cycle_count;
    bit            gap_enable;
    bit            stall_enable;
    int            stall_left;

    belt_block_cipher_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // s-box on every byte, then rotate left
    function automatic logic [31:0] sub_rotl(input logic [31:0] u, input int unsigned r);
        logic [31:0] h;
        for (int k = 0; k < 4; k++) begin
            h[8*k +: 8] = H_BOX[u[8*k +: 8]];
        end
        return (h << r) | (h >> (32 - r));
    endfunction

    function automatic key_t expand_key();
        key_t w;
        for (int i = 0; i < 4; i++) begin
            w[2*i]   = key_regs[i][31:0];
            w[2*i+1] = key_regs[i][63:32];
        end
        case (key_mode)
            MODE_128: begin
                for (int i = 0; i < 4; i++) begin
                    w[4+i] = w[i];
                end
            end
            MODE_192: begin
                w[6] = w[0] ^ w[1] ^ w[2];
                w[7] = w[3] ^ w[4] ^ w[5];
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    // round key j, counted from 1, wraps over the eight key words
    function automatic logic [31:0] round_key(input key_t w, input int j);
        return w[(j - 1) % 8];
    endfunction

    function automatic blk_t cipher_block(input logic act, input logic [63:0] lo,
                                          input logic [63:0] hi);
        key_t        w;
        logic [31:0] a, b, c, d, e, t;
        blk_t        r;
        w = expand_key();
        a = lo[31:0];
        b = lo[63:32];
        c = hi[31:0];
        d = hi[63:32];
        if (act == ACT_ENCRYPT) begin
            for (int i = 1; i <= ROUNDS; i++) begin
                b ^= sub_rotl(a + round_key(w, 7*i - 6), 5);
                c ^= sub_rotl(d + round_key(w, 7*i - 5), 21);
                a -= sub_rotl(b + round_key(w, 7*i - 4), 13);
                e = sub_rotl(b + c + round_key(w, 7*i - 3), 21) ^ 32'(i);
                b += e;
                c -= e;
                d += sub_rotl(c + round_key(w, 7*i - 2), 13);
                b ^= sub_rotl(a + round_key(w, 7*i - 1), 21);
                c ^= sub_rotl(d + round_key(w, 7*i), 5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = b; b = c; c = t;
            end
            r.lo = {d, b};
            r.hi = {c, a};
        end else begin
            for (int i = ROUNDS; i >= 1; i--) begin
                b ^= sub_rotl(a + round_key(w, 7*i), 5);
                c ^= sub_rotl(d + round_key(w, 7*i - 1), 21);
                a -= sub_rotl(b + round_key(w, 7*i - 2), 13);
                e = sub_rotl(b + c + round_key(w, 7*i - 3), 21) ^ 32'(i);
                b += e;
                c -= e;
                d += sub_rotl(c + round_key(w, 7*i - 4), 13);
                b ^= sub_rotl(a + round_key(w, 7*i - 5), 21);
                c ^= sub_rotl(d + round_key(w, 7*i - 6), 5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = a; a = d; d = t;
            end
            r.lo = {a, c};
            r.hi = {b, d};
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_word64();
        int unsigned pick;
        pick = $urandom_range(15, 0);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return ONES;
        end
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic add_write(input logic [2:0] idx, input logic [63:0] val);
        row_t r;
        r = '{kind: ROW_WRITE, idx: idx, val: val, default: '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_block(input logic act, input logic [63:0] lo, input logic [63:0] hi);
        row_t r;
        r = '{kind: ROW_BLOCK, act: act, lo: lo, hi: hi, default: '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_known(input logic act, input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] exp_lo, input logic [63:0] exp_hi);
        row_t r;
        r = '{kind: ROW_KNOWN, act: act, lo: lo, hi: hi, exp_lo: exp_lo, exp_hi: exp_hi,
              default: '0};
        directed_rows.push_back(r);
    endtask

    // one block on the input stream; the expectation is logged at acceptance
    task automatic send_block(input logic act, input logic [63:0] lo, input logic [63:0] hi,
                              input bit known, input blk_t known_res);
        if (gap_enable && $urandom_range(7, 0) == 0) begin
            repeat ($urandom_range(16, 1)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        expected_blocks.push_back(known ? known_res : cipher_block(act, lo, hi));
    endtask

    // stop sending and let every pending result come out
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_KEY_PART_0: key_regs[0] = val;
            REG_KEY_PART_1: key_regs[1] = val;
            REG_KEY_PART_2: key_regs[2] = val;
            REG_KEY_PART_3: key_regs[3] = val;
            REG_KEY_MODE:   key_mode    = val[1:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("belt_block_cipher_unit verification failed");
            $finish;
        end
    end

    // result side: random stall bursts on m_tready
    initial begin
        m_tready   = 1'b1;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_enable && stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (stall_enable && $urandom_range(9, 0) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(15, 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        blk_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", m_tdata));
            end else begin
                want = expected_blocks.pop_front();
                if (m_tdata[63:0] !== want.lo) begin
                    report_mismatch($sformatf("result_low %h, want %h",
                                              m_tdata[63:0], want.lo));
                end
                if (m_tdata[127:64] !== want.hi) begin
                    report_mismatch($sformatf("result_high %h, want %h",
                                              m_tdata[127:64], want.hi));
                end
            end
        end
    end

    initial begin
        row_t        r;
        logic [1:0]  mode_pick;
        bit          quiet;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        error_count  = 0;
        cycle_count  = 0;
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
        key_regs     = '{default: '0};
        key_mode     = MODE_256;

        // directed part: reset key, published vector, every key length
        add_block(ACT_ENCRYPT, '0, '0);
        add_block(ACT_DECRYPT, '0, '0);
        add_block(ACT_ENCRYPT, ONES, ONES);
        add_block(ACT_DECRYPT, ONES, ONES);
        add_write(REG_KEY_PART_0, STD_KEY_0);
        add_write(REG_KEY_PART_1, STD_KEY_1);
        add_write(REG_KEY_PART_2, STD_KEY_2);
        add_write(REG_KEY_PART_3, STD_KEY_3);
        add_known(ACT_ENCRYPT, STD_PT_LO, STD_PT_HI, STD_CT_LO, STD_CT_HI);
        add_known(ACT_DECRYPT, STD_CT_LO, STD_CT_HI, STD_PT_LO, STD_PT_HI);
        add_block(ACT_ENCRYPT, '0, '0);
        add_block(ACT_DECRYPT, ONES, ONES);
        add_write(REG_KEY_MODE, 64'(MODE_128));
        add_block(ACT_ENCRYPT, STD_PT_LO, STD_PT_HI);
        add_block(ACT_DECRYPT, STD_PT_LO, STD_PT_HI);
        // upper key parts must not matter for a 128-bit key
        add_write(REG_KEY_PART_3, ONES);
        add_block(ACT_ENCRYPT, STD_PT_LO, STD_PT_HI);
        add_write(REG_KEY_MODE, 64'(MODE_192));
        add_block(ACT_ENCRYPT, STD_PT_LO, STD_PT_HI);
        add_block(ACT_DECRYPT, STD_CT_LO, STD_CT_HI);
        add_block(ACT_ENCRYPT, ONES, ONES);
        // all ones in the mode register gives mode 3, same as a 256-bit key
        add_write(REG_KEY_PART_3, STD_KEY_3);
        add_write(REG_KEY_MODE, ONES);
        add_known(ACT_ENCRYPT, STD_PT_LO, STD_PT_HI, STD_CT_LO, STD_CT_HI);
        add_known(ACT_DECRYPT, STD_CT_LO, STD_CT_HI, STD_PT_LO, STD_PT_HI);
        // unmapped cfg indexes leave the key alone
        add_write(REG_UNMAPPED_FIRST, ONES);
        add_write(REG_UNMAPPED_LAST, '0);
        add_known(ACT_ENCRYPT, STD_PT_LO, STD_PT_HI, STD_CT_LO, STD_CT_HI);
        add_write(REG_KEY_PART_0, ONES);
        add_write(REG_KEY_PART_1, ONES);
        add_write(REG_KEY_PART_2, ONES);
        add_write(REG_KEY_PART_3, ONES);
        add_write(REG_KEY_MODE, 64'(MODE_256));
        add_block(ACT_ENCRYPT, '0, '0);
        add_block(ACT_DECRYPT, '0, '0);
        add_block(ACT_ENCRYPT, ONES, ONES);
        add_block(ACT_DECRYPT, ONES, ONES);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_WRITE) begin
                wait_idle();
                write_reg(r.idx, r.val);
            end else begin
                send_block(r.act, r.lo, r.hi, r.kind == ROW_KNOWN, '{hi: r.exp_hi, lo: r.exp_lo});
            end
        end

        // random part: new key and mode per phase; last phase has no gaps or stalls
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiet = (ph == NUM_PHASES - 1);
            wait_idle();
            gap_enable   = !quiet && ($urandom_range(3, 0) != 0);
            stall_enable = !quiet && ($urandom_range(3, 0) != 0);
            write_reg(REG_KEY_PART_0, rand_word64());
            write_reg(REG_KEY_PART_1, rand_word64());
            write_reg(REG_KEY_PART_2, rand_word64());
            write_reg(REG_KEY_PART_3, rand_word64());
            mode_pick = 2'(ph);
            write_reg(REG_KEY_MODE, {$urandom, 30'($urandom), mode_pick});
            if ($urandom_range(2, 0) == 0) begin
                write_reg(3'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST)),
                          rand_word64());
            end
            repeat (PHASE_ITEMS) begin
                send_block(1'($urandom_range(1, 0)), rand_word64(), rand_word64(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("belt_block_cipher_unit verification clean");
        end else begin
            $display("belt_block_cipher_unit verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/belt_pkg.sv
src/belt_key_sched.sv
src/belt_round.sv
src/belt_out_skid.sv
src/belt_block_cipher_unit.sv
dv/tb_top.sv
